FILE: sv/dsst_pkg.sv
// Shared types and codes for the dual-slave SPI transmit scheduler.
package dsst_pkg;

    typedef enum logic [1:0] {
        OP_ENQ  = 2'd0,
        OP_DONE = 2'd1,
        OP_READ = 2'd2,
        OP_NOP  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_DROP      = 2'd1,
        STAT_IDLE_DONE = 2'd2,
        STAT_RSVD      = 2'd3
    } stat_t;

    // Slave service code: none yet / idle, slave one, slave two
    typedef enum logic [1:0] {
        SRV_NONE = 2'd0,
        SRV_ONE  = 2'd1,
        SRV_TWO  = 2'd2,
        SRV_RSVD = 2'd3
    } srv_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_PICK,
        S_FETCH,
        S_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic pick;
        logic capture;
    } cmd_t;

    localparam int unsigned IN_TDATA_W  = 8;
    localparam int unsigned IN_TUSER_W  = 3;
    localparam int unsigned OUT_TDATA_W = 24;

endpackage

FILE: sv/dsst_ram.sv
// Generic simple dual-port RAM with registered read.
module dsst_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: sv/dsst_queue.sv
// Byte ring queue: pointers, fill count and one RAM.
module dsst_queue #(
    parameter int unsigned DEPTH = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic [7:0] push_data,
    input  logic       pop,
    output logic [7:0] pop_data,
    output logic       nonempty,
    output logic       full
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_push, do_pop;

    assign nonempty = (cnt_reg != '0);
    assign full     = (cnt_reg == CW'(DEPTH));
    assign do_push  = push && !full;
    assign do_pop   = pop && nonempty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    dsst_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (do_push),
        .waddr (wr_ptr_reg),
        .wdata (push_data),
        .re    (do_pop),
        .raddr (rd_ptr_reg),
        .rdata (pop_data)
    );

endmodule

FILE: sv/dsst_ctrl.sv
// Controller: sequences accept, execute, pick, fetch and output of one item.
module dsst_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    output dsst_pkg::cmd_t cmd
);

    import dsst_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_PICK;
            end
            S_PICK:
            begin
                cmd.pick   = 1'b1;
                state_next = S_FETCH;
            end
            S_FETCH:
            begin
                cmd.capture = 1'b1;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // one item in flight: never taking input while a result is offered
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input accepted while result pending");

endmodule

FILE: sv/dsst_dp.sv
// Datapath: queues, receive bytes, flags, round-robin pick, result registers.
module dsst_dp #(
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  dsst_pkg::cmd_t      cmd,
    input  logic [1:0]          opcode,
    input  logic                slave_sel,
    input  logic [7:0]          data_byte,
    output logic                tx_start,
    output logic                tx_slave,
    output logic [7:0]          tx_byte,
    output logic [7:0]          read_data,
    output logic [1:0]          new_flags,
    output logic                busy_res,
    output logic [1:0]          status
);

    import dsst_pkg::*;

    // latched item
    op_t        op_reg, op_next;
    logic       sel_reg, sel_next;
    logic [7:0] data_reg, data_next;

    // scheduler state
    srv_t       active_reg, active_next;
    srv_t       last_reg, last_next;
    logic [7:0] rx1_reg, rx1_next;
    logic [7:0] rx2_reg, rx2_next;
    logic [1:0] flags_reg, flags_next;
    logic       start_req_reg, start_req_next;

    // result
    stat_t      stat_reg, stat_next;
    logic [7:0] rdata_reg, rdata_next;
    logic       started_reg, started_next;
    logic       tx_slave_reg, tx_slave_next;
    logic [7:0] tx_byte_reg, tx_byte_next;

    // queues
    logic       push1, push2, pop1, pop2;
    logic [7:0] q1_data, q2_data;
    logic       q1_ne, q2_ne, q1_full, q2_full;
    srv_t       pick;

    always_comb
    begin
        if (q1_ne && q2_ne)
        begin
            pick = (last_reg == SRV_ONE) ? SRV_TWO : SRV_ONE;
        end
        else if (q1_ne)
        begin
            pick = SRV_ONE;
        end
        else if (q2_ne)
        begin
            pick = SRV_TWO;
        end
        else
        begin
            pick = SRV_NONE;
        end
    end

    always_comb
    begin
        op_next        = op_reg;
        sel_next       = sel_reg;
        data_next      = data_reg;
        active_next    = active_reg;
        last_next      = last_reg;
        rx1_next       = rx1_reg;
        rx2_next       = rx2_reg;
        flags_next     = flags_reg;
        start_req_next = start_req_reg;
        stat_next      = stat_reg;
        rdata_next     = rdata_reg;
        started_next   = started_reg;
        tx_slave_next  = tx_slave_reg;
        tx_byte_next   = tx_byte_reg;
        push1          = 1'b0;
        push2          = 1'b0;
        pop1           = 1'b0;
        pop2           = 1'b0;

        if (cmd.load)
        begin
            op_next   = op_t'(opcode);
            sel_next  = slave_sel;
            data_next = data_byte;
        end

        if (cmd.exec)
        begin
            stat_next      = STAT_OK;
            rdata_next     = '0;
            start_req_next = 1'b0;
            unique case (op_reg)
                OP_ENQ:
                begin
                    if (sel_reg)
                    begin
                        if (q2_full)
                        begin
                            stat_next = STAT_DROP;
                        end
                        else
                        begin
                            push2 = 1'b1;
                        end
                    end
                    else
                    begin
                        if (q1_full)
                        begin
                            stat_next = STAT_DROP;
                        end
                        else
                        begin
                            push1 = 1'b1;
                        end
                    end
                    start_req_next = (active_reg == SRV_NONE);
                end
                OP_DONE:
                begin
                    unique case (active_reg)
                        SRV_ONE:
                        begin
                            rx1_next       = data_reg;
                            flags_next[0]  = 1'b1;
                            start_req_next = 1'b1;
                        end
                        SRV_TWO:
                        begin
                            rx2_next       = data_reg;
                            flags_next[1]  = 1'b1;
                            start_req_next = 1'b1;
                        end
                        default:
                        begin
                            stat_next = STAT_IDLE_DONE;
                        end
                    endcase
                end
                OP_READ:
                begin
                    if (sel_reg)
                    begin
                        rdata_next    = rx2_reg;
                        flags_next[1] = 1'b0;
                    end
                    else
                    begin
                        rdata_next    = rx1_reg;
                        flags_next[0] = 1'b0;
                    end
                end
                OP_NOP:
                begin
                end
            endcase
        end

        if (cmd.pick)
        begin
            started_next  = 1'b0;
            tx_slave_next = 1'b0;
            if (start_req_reg)
            begin
                active_next = pick;
                if (pick != SRV_NONE)
                begin
                    last_next     = pick;
                    started_next  = 1'b1;
                    tx_slave_next = (pick == SRV_TWO);
                    pop1          = (pick == SRV_ONE);
                    pop2          = (pick == SRV_TWO);
                end
            end
        end

        if (cmd.capture)
        begin
            tx_byte_next = started_reg ? (tx_slave_reg ? q2_data : q1_data) : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        sel_reg       <= sel_next;
        data_reg      <= data_next;
        rdata_reg     <= rdata_next;
        tx_slave_reg  <= tx_slave_next;
        tx_byte_reg   <= tx_byte_next;
        stat_reg      <= stat_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= SRV_NONE;
            last_reg      <= SRV_NONE;
            rx1_reg       <= '0;
            rx2_reg       <= '0;
            flags_reg     <= '0;
            start_req_reg <= 1'b0;
            started_reg   <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            last_reg      <= last_next;
            rx1_reg       <= rx1_next;
            rx2_reg       <= rx2_next;
            flags_reg     <= flags_next;
            start_req_reg <= start_req_next;
            started_reg   <= started_next;
        end
    end

    dsst_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_q1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push1),
        .push_data (data_reg),
        .pop       (pop1),
        .pop_data  (q1_data),
        .nonempty  (q1_ne),
        .full      (q1_full)
    );

    dsst_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_q2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push2),
        .push_data (data_reg),
        .pop       (pop2),
        .pop_data  (q2_data),
        .nonempty  (q2_ne),
        .full      (q2_full)
    );

    assign tx_start  = started_reg;
    assign tx_slave  = tx_slave_reg;
    assign tx_byte   = tx_byte_reg;
    assign read_data = rdata_reg;
    assign new_flags = flags_reg;
    assign busy_res  = (active_reg != SRV_NONE);
    assign status    = stat_reg;

    // a started transfer always leaves the master busy
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.capture && started_reg) |-> (active_reg != SRV_NONE))
        else $error("transfer started but master idle");

    // completion while idle never starts a transfer
    a_idle_done: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.pick && start_req_reg) |-> (stat_reg != STAT_IDLE_DONE))
        else $error("start requested after idle completion");

    // with both queues loaded, service alternates
    a_alternate: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.pick && start_req_reg && q1_ne && q2_ne)
            |=> (active_reg != $past(last_reg)))
        else $error("round robin did not alternate");

endmodule

FILE: sv/dual_slave_spi_tx_scheduler.sv
// Top level of the dual-slave SPI transmit scheduler.
// Result path: after the input accept edge the item passes the execute, pick (with
//   queue RAM read) and capture steps; the result then holds until taken.
// Flow: each item steps through accept, execute, pick, fetch and output; the FSM
//   handles one item at a time and takes no new item until the result is taken.
// Reset: rst_n async active low; queues empty, master idle, no slave served,
//   receive bytes and unread flags zero. Queue RAM contents are not cleared.
module dual_slave_spi_tx_scheduler #(
    parameter int unsigned QUEUE_DEPTH = 16   // bytes per slave queue, 2..256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // input items
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [dsst_pkg::IN_TDATA_W-1:0]     s_tdata,   // [7:0] data_byte
    input  logic [dsst_pkg::IN_TUSER_W-1:0]     s_tuser,   // [1:0] opcode, [2] slave_sel
    // result items
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [dsst_pkg::OUT_TDATA_W-1:0]    m_tdata    // [0] tx_start, [1] tx_slave,
                                                           // [9:2] tx_byte,
                                                           // [17:10] read_data,
                                                           // [19:18] new_flags,
                                                           // [20] busy_res,
                                                           // [22:21] status, [23] zero
);

    import dsst_pkg::*;

    cmd_t       cmd;
    logic       tx_start;
    logic       tx_slave;
    logic [7:0] tx_byte;
    logic [7:0] read_data;
    logic [1:0] new_flags;
    logic       busy_res;
    logic [1:0] status;

    // Controller: one state per step, handshakes on both sides.
    dsst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // Datapath: two ring queues, receive registers, flags and arbitration.
    dsst_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .opcode    (s_tuser[1:0]),
        .slave_sel (s_tuser[2]),
        .data_byte (s_tdata),
        .tx_start  (tx_start),
        .tx_slave  (tx_slave),
        .tx_byte   (tx_byte),
        .read_data (read_data),
        .new_flags (new_flags),
        .busy_res  (busy_res),
        .status    (status)
    );

    // result fields packed low to high, padded to a whole byte
    assign m_tdata = {1'b0, status, busy_res, new_flags, read_data,
                      tx_byte, tx_slave, tx_start};

endmodule
